>>> sv/drr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_pkg: shared types and constants for the decimal rescaler
// status codes, divider sideband and the power-of-ten table
// ----------------------------------------------------------------------------
package drr_pkg;

   localparam int MaxDecExp = 18;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_DIV0 = 2'd1;
   localparam status_type ST_EXP  = 2'd2;
   localparam status_type ST_OVF  = 2'd3;

   // travels alongside an item through the divider
   typedef struct packed {
      status_type         status;
      logic               rneg;
      logic signed [31:0] bias;
   } side_type;

   function automatic logic [59:0] pow10(input logic [4:0] n);
      logic [59:0] p;
      case (n)
         5'd0:  p = 60'd1;
         5'd1:  p = 60'd10;
         5'd2:  p = 60'd100;
         5'd3:  p = 60'd1000;
         5'd4:  p = 60'd10000;
         5'd5:  p = 60'd100000;
         5'd6:  p = 60'd1000000;
         5'd7:  p = 60'd10000000;
         5'd8:  p = 60'd100000000;
         5'd9:  p = 60'd1000000000;
         5'd10: p = 60'd10000000000;
         5'd11: p = 60'd100000000000;
         5'd12: p = 60'd1000000000000;
         5'd13: p = 60'd10000000000000;
         5'd14: p = 60'd100000000000000;
         5'd15: p = 60'd1000000000000000;
         5'd16: p = 60'd10000000000000000;
         5'd17: p = 60'd100000000000000000;
         5'd18: p = 60'd1000000000000000000;
         default: p = 60'd1;
      endcase
      return p;
   endfunction

endpackage

>>> sv/decimal_rescale_round_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_rescale_round_top: decimal fixed-point rescaler
// returns round(mantissa * 10^exponent * multiplier / divisor) + bias
// ----------------------------------------------------------------------------
// One item enters per clock and one result leaves per clock unless a held
// result stalls the pipeline. An item passes through six stages of decode and
// multiplication, 64 stages of the bit-per-stage divider, and the output
// register where rounding sign and bias are applied. The whole pipeline
// advances whenever the output register is empty or being taken, so a held
// result freezes it without losing or repeating an item. Rounding is half
// away from zero; a negative exponent scales the divisor instead. Status
// 1 zero divisor, 2 exponent magnitude above 18, 3 overflow; value is 0 then.
module decimal_rescale_round_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [63:0]  req_mantissa,
   input  logic signed [7:0]   req_exponent,
   input  logic signed [31:0]  req_multiplier,
   input  logic signed [31:0]  req_divisor,
   input  logic signed [31:0]  req_bias,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [63:0]  rsp_scaled_value,
   output drr_pkg::status_type rsp_status
);
   import drr_pkg::*;

   // per-stage working set, unused fields trimmed by synthesis
   typedef struct packed {
      status_type         status;
      logic [63:0]        nm;
      logic [63:0]        dm;
      logic               ns;
      logic               ds;
      logic               es;
      logic               ms;
      logic [31:0]        mm;
      logic [59:0]        p;
      logic signed [31:0] bias;
   } work_type;

   logic        en;
   logic [5:0]  vld_ff;

   work_type    s1_in, s1_ff, s2_ff, s3_in, s3_ff, s4_ff, s5_in, s5_ff;
   logic [63:0] pp0_ff, pp2_ff;
   logic [59:0] pp1_ff, pp3_ff;
   logic [63:0] qq0_ff, qq1_ff;

   logic [63:0] dvd_in, dvd_ff, dvs_ff;
   side_type    side_in, side_ff;

   logic        div_valid;
   logic [63:0] div_quot;
   side_type    div_side;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_value_in, rsp_value_ff;
   status_type         rsp_status_in, rsp_status_ff;

   // pipeline moves whenever the output register can take a result
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // decode: magnitudes, early status, power of ten
   always_comb begin
      logic [7:0]  em;
      logic [31:0] mu, du;
      s1_in      = '0;
      mu         = $unsigned(req_multiplier);
      du         = $unsigned(req_divisor);
      s1_in.ns   = req_mantissa[63];
      s1_in.es   = req_exponent[7];
      s1_in.ms   = req_multiplier[31];
      s1_in.ds   = req_divisor[31];
      s1_in.nm   = s1_in.ns ? (64'd0 - $unsigned(req_mantissa)) : $unsigned(req_mantissa);
      em         = s1_in.es ? (8'd0 - $unsigned(req_exponent)) : $unsigned(req_exponent);
      s1_in.mm   = s1_in.ms ? (32'd0 - mu) : mu;
      s1_in.dm   = {32'd0, (s1_in.ds ? (32'd0 - du) : du)};
      s1_in.bias = req_bias;
      s1_in.p    = 60'd1;
      if (s1_in.dm == 64'd0) begin
         s1_in.status = ST_DIV0;
      end else if (em > 8'(MaxDecExp)) begin
         s1_in.status = ST_EXP;
      end else begin
         s1_in.status = ST_OK;
         s1_in.p      = pow10(em[4:0]);
      end
   end

   // power of ten product: partials are formed on the mantissa or divisor
   logic [63:0] a_op;
   assign a_op = s1_ff.es ? s1_ff.dm : s1_ff.nm;

   // sum the partials and check the 64 bit limit for the result sign
   always_comb begin
      logic [127:0] prod;
      logic         neg;
      s3_in = s2_ff;
      prod  = 128'(pp0_ff) + (128'(pp1_ff) << 32) + (128'(pp2_ff) << 32)
            + (128'(pp3_ff) << 64);
      neg   = s2_ff.es ? s2_ff.ds : s2_ff.ns;
      if (prod > {64'd0, neg, {63{~neg}}} && s2_ff.status == ST_OK) begin
         s3_in.status = ST_OVF;
      end
      if (s2_ff.es) begin
         s3_in.dm = prod[63:0];
      end else begin
         s3_in.nm = prod[63:0];
      end
   end

   // multiplier product and its limit check
   always_comb begin
      logic [95:0] prod;
      logic        neg;
      s5_in = s4_ff;
      prod  = 96'(qq0_ff) + (96'(qq1_ff) << 32);
      neg   = s4_ff.ns ^ s4_ff.ms;
      if (prod > {32'd0, neg, {63{~neg}}} && s4_ff.status == ST_OK) begin
         s5_in.status = ST_OVF;
      end
      s5_in.nm = prod[63:0];
      s5_in.ns = neg;
   end

   // rounding offset of half the divisor; cannot wrap
   assign dvd_in         = s5_ff.nm + {1'b0, s5_ff.dm[63:1]};
   assign side_in.status = s5_ff.status;
   assign side_in.rneg   = s5_ff.ns ^ s5_ff.ds;
   assign side_in.bias   = s5_ff.bias;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], req_valid};
      end
      if (en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         pp0_ff  <= a_op[31:0] * s1_ff.p[31:0];
         pp1_ff  <= a_op[31:0] * s1_ff.p[59:32];
         pp2_ff  <= a_op[63:32] * s1_ff.p[31:0];
         pp3_ff  <= a_op[63:32] * s1_ff.p[59:32];
         s3_ff   <= s3_in;
         s4_ff   <= s3_ff;
         qq0_ff  <= s3_ff.nm[31:0] * s3_ff.mm;
         qq1_ff  <= s3_ff.nm[63:32] * s3_ff.mm;
         s5_ff   <= s5_in;
         dvd_ff  <= dvd_in;
         dvs_ff  <= s5_ff.dm;
         side_ff <= side_in;
      end
   end

   drr_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vld_ff[5]),
      .in_dividend (dvd_ff),
      .in_divisor  (dvs_ff),
      .in_side     (side_ff),
      .out_valid   (div_valid),
      .out_quot    (div_quot),
      .out_side    (div_side)
   );

   // sign, quotient range and bias; any error forces the value to zero
   always_comb begin
      logic [63:0] v, b, r;
      status_type  st;
      st = div_side.status;
      if (st == ST_OK && !div_side.rneg && div_quot[63]) begin
         st = ST_OVF;
      end
      v = div_side.rneg ? (64'd0 - div_quot) : div_quot;
      b = {{32{div_side.bias[31]}}, div_side.bias};
      r = v + b;
      if (st == ST_OK && ((v[63] ^ r[63]) & (b[63] ^ r[63]))) begin
         st = ST_OVF;
      end
      rsp_status_in = st;
      rsp_value_in  = (st == ST_OK) ? r : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
      if (en) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

   // an error result never carries a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_scaled_value == 64'sd0)
      else $error("error item with nonzero value");

   // a stalled pipeline neither gains nor drops items
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline valids moved during stall");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> sv/drr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_divider: pipelined unsigned 64 by 64 divider
// restoring division, one quotient bit per register stage
// ----------------------------------------------------------------------------
module drr_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [63:0]        in_dividend,
   input  logic [63:0]        in_divisor,
   input  drr_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [63:0]        out_quot,
   output drr_pkg::side_type  out_side
);
   import drr_pkg::*;

   localparam int Steps = 64;

   logic [Steps-1:0] valid_ff;
   logic [63:0]      rem_ff  [Steps];
   logic [63:0]      quo_ff  [Steps];
   logic [63:0]      dvs_ff  [Steps];
   side_type         side_ff [Steps];

   logic [63:0]      rem_src [Steps];
   logic [63:0]      quo_src [Steps];
   logic [63:0]      dvs_src [Steps];
   side_type         side_src[Steps];
   logic [Steps-1:0] valid_src;

   genvar k;
   generate
      for (k = 0; k < Steps; k++) begin : g_step
         logic [64:0] shifted;
         logic [64:0] diff;
         logic        ge;
         logic [63:0] rem_in;
         logic [63:0] quo_in;

         if (k == 0) begin : g_first
            assign rem_src[k]   = 64'd0;
            assign quo_src[k]   = in_dividend;
            assign dvs_src[k]   = in_divisor;
            assign side_src[k]  = in_side;
            assign valid_src[k] = in_valid;
         end else begin : g_next
            assign rem_src[k]   = rem_ff[k-1];
            assign quo_src[k]   = quo_ff[k-1];
            assign dvs_src[k]   = dvs_ff[k-1];
            assign side_src[k]  = side_ff[k-1];
            assign valid_src[k] = valid_ff[k-1];
         end

         always_comb begin
            shifted = {rem_src[k], quo_src[k][63]};
            diff    = shifted - {1'b0, dvs_src[k]};
            ge      = (shifted >= {1'b0, dvs_src[k]});
            rem_in  = ge ? diff[63:0] : shifted[63:0];
            quo_in  = {quo_src[k][62:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_src[k];
            end
            if (en) begin
               rem_ff[k]  <= rem_in;
               quo_ff[k]  <= quo_in;
               dvs_ff[k]  <= dvs_src[k];
               side_ff[k] <= side_src[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[Steps-1];
   assign out_quot  = quo_ff[Steps-1];
   assign out_side  = side_ff[Steps-1];

endmodule
